/* rtl/core/gcc_pkg.sv */
// Shared constants and types for the graph connectivity check unit.
// No dependencies; imported by gcc_ctrl, the top level and the testbench.
package gcc_pkg;

  localparam int unsigned MaxVertsDef = 64;  // default vertex capacity
  localparam int unsigned CountW      = 7;   // width of vertex numbers and the count
  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned ApbAddrW    = 3;

  // APB word index of the configuration register
  localparam logic RegVertexCount = 1'b0;

  typedef struct packed {
    logic check_done;
    logic connected;
    logic edge_rejected;
  } res_t;

endpackage

/* rtl/core/graph_connectivity_check_unit.sv */
// Graph connectivity check unit: edge load, depth-first walk, APB config register.
// Depends on gcc_pkg and gcc_ctrl (which holds the adjacency and stack RAMs).
// Edge word: result strobed the cycle after acceptance; a rejected edge leaves the unit
//   idle, else it stays busy for the read-modify-write of one row (self-loop) or two.
// Check word: one adjacency read per vertex reached (R vertices, P = R - 1 pushes) and a
//   stack access per push or pop; result strobed as busy falls.
// Reset clears the graph and the walk state at once; vertex_count resets to 1.
module graph_connectivity_check_unit #(
  parameter int unsigned MaxVerts = gcc_pkg::MaxVertsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic [gcc_pkg::CountW-1:0]    vertex_a_i,
  input  logic [gcc_pkg::CountW-1:0]    vertex_b_i,
  output logic                          done_o,
  output logic                          check_done_o,
  output logic                          connected_o,
  output logic                          edge_rejected_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [gcc_pkg::ApbDataW-1:0]  pwdata,
  output logic [gcc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  import gcc_pkg::*;

  logic [CountW-1:0] vcount_q;
  res_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CountW'(1);
    end else if (psel && penable && pwrite && (paddr[2] == RegVertexCount)) begin
      vcount_q <= pwdata[CountW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegVertexCount) ?
                  {{(ApbDataW - CountW){1'b0}}, vcount_q} : '0;

  gcc_ctrl #(.MaxVerts(MaxVerts)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .vertex_count_i (vcount_q),
    .busy_o         (busy),
    .done_o         (done_o),
    .res_o          (res)
  );

  assign check_done_o    = res.check_done;
  assign connected_o     = res.connected;
  assign edge_rejected_o = res.edge_rejected;

  // an edge word answers on the very next cycle
  property p_edge_answer;
    @(posedge clk_i) disable iff (!rst_ni)
      (start && !busy && !cmd_i) |=> (done_o && !check_done_o && !connected_o);
  endproperty
  a_edge_answer: assert property (p_edge_answer) else $error("edge word not answered");

  // a check word keeps the unit busy until its walk ends
  property p_check_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (start && !busy && cmd_i) |=> (busy && !done_o);
  endproperty
  a_check_busy: assert property (p_check_busy) else $error("check word not walked");

  // a check answer only appears as the walk finishes
  property p_check_end;
    @(posedge clk_i) disable iff (!rst_ni)
      (done_o && check_done_o) |-> ($past(busy) && !busy && !edge_rejected_o);
  endproperty
  a_check_end: assert property (p_check_end) else $error("stray check answer");

endmodule

/* rtl/core/gcc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used for the adjacency rows and the pending-vertex stack.
module gcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-during-write to the same entry returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/gcc_ctrl.sv */
// Sequencer for edge loading and the depth-first walk over the adjacency RAM.
// Depends on gcc_pkg and two gcc_ram instances (adjacency rows, pending stack).
module gcc_ctrl #(
  parameter int unsigned MaxVerts = gcc_pkg::MaxVertsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        cmd_i,
  input  logic [gcc_pkg::CountW-1:0]  vertex_a_i,
  input  logic [gcc_pkg::CountW-1:0]  vertex_b_i,
  input  logic [gcc_pkg::CountW-1:0]  vertex_count_i,
  output logic                        busy_o,
  output logic                        done_o,
  output gcc_pkg::res_t               res_o
);

  import gcc_pkg::*;

  localparam int unsigned AW = $clog2(MaxVerts);
  localparam int unsigned DW = $clog2(MaxVerts + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EDGE_B = 7'b0000010,
    S_EDGE_C = 7'b0000100,
    S_POP    = 7'b0001000,
    S_STK    = 7'b0010000,
    S_ROW    = 7'b0100000,
    S_PUSH   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       ra_q, ra_d, rb_q, rb_d;
  logic [AW-1:0]       xrd_q, xrd_d;       // row address of the read in flight
  logic [MaxVerts-1:0] row_vld_q, row_vld_d;
  logic [MaxVerts-1:0] visited_q, visited_d;
  logic [MaxVerts-1:0] pend_q, pend_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic                done_q, done_d;
  res_t                res_q, res_d;

  logic                adj_we;
  logic [AW-1:0]       adj_waddr;
  logic [MaxVerts-1:0] adj_wdata, adj_rdata;
  logic                stk_we;
  logic [AW-1:0]       stk_rdata;

  logic [CountW-1:0]   n_eff;
  logic [MaxVerts-1:0] vmask;
  logic                accept, bad;
  logic [CountW-1:0]   a_m1, b_m1;
  logic [MaxVerts-1:0] row_val, nb, lsb_oh;
  logic [AW-1:0]       lsb_idx;
  logic [DW-1:0]       depth_m1;

  gcc_ram #(.Width(MaxVerts), .Depth(MaxVerts)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (xrd_d),
    .rdata_o (adj_rdata)
  );

  gcc_ram #(.Width(AW), .Depth(MaxVerts)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q[AW-1:0]),
    .wdata_i (lsb_idx),
    .raddr_i (depth_m1[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  // effective vertex count, clamped to 1..MaxVerts
  always_comb begin
    if (vertex_count_i == '0) begin
      n_eff = CountW'(1);
    end else if (vertex_count_i > CountW'(MaxVerts)) begin
      n_eff = CountW'(MaxVerts);
    end else begin
      n_eff = vertex_count_i;
    end
  end

  always_comb begin
    for (int j = 0; j < MaxVerts; j++) begin
      vmask[j] = (CountW'(j) < n_eff);
    end
  end

  assign accept   = start && (state_q == S_IDLE);
  assign bad      = (vertex_a_i == '0) || (vertex_b_i == '0) ||
                    (vertex_a_i > n_eff) || (vertex_b_i > n_eff);
  assign a_m1     = vertex_a_i - CountW'(1);
  assign b_m1     = vertex_b_i - CountW'(1);
  assign depth_m1 = depth_q - DW'(1);

  // rows never written since reset or the last check read as zero
  assign row_val = row_vld_q[xrd_q] ? adj_rdata : '0;
  assign nb      = row_val & vmask & ~visited_q;
  assign lsb_oh  = pend_q & (~pend_q + MaxVerts'(1));

  always_comb begin
    lsb_idx = '0;
    for (int j = 0; j < MaxVerts; j++) begin
      if (lsb_oh[j]) begin
        lsb_idx = lsb_idx | AW'(j);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    xrd_d     = xrd_q;
    row_vld_d = row_vld_q;
    visited_d = visited_q;
    pend_d    = pend_q;
    depth_d   = depth_q;
    done_d    = 1'b0;
    res_d     = res_q;
    adj_we    = 1'b0;
    adj_waddr = ra_q;
    adj_wdata = row_val | (MaxVerts'(1) << rb_q);
    stk_we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i) begin
            // vertex one is visited and its row fetched straight away
            visited_d = MaxVerts'(1);
            depth_d   = '0;
            xrd_d     = '0;
            state_d   = S_ROW;
          end else begin
            done_d = 1'b1;
            res_d  = '{check_done: 1'b0, connected: 1'b0, edge_rejected: bad};
            if (!bad) begin
              ra_d    = a_m1[AW-1:0];
              rb_d    = b_m1[AW-1:0];
              xrd_d   = a_m1[AW-1:0];
              state_d = S_EDGE_B;
            end
          end
        end
      end
      S_EDGE_B: begin
        adj_we          = 1'b1;
        row_vld_d[ra_q] = 1'b1;
        // a self-loop touches one row only
        if (ra_q == rb_q) begin
          state_d = S_IDLE;
        end else begin
          xrd_d   = rb_q;
          state_d = S_EDGE_C;
        end
      end
      S_EDGE_C: begin
        adj_we          = 1'b1;
        adj_waddr       = rb_q;
        adj_wdata       = row_val | (MaxVerts'(1) << ra_q);
        row_vld_d[rb_q] = 1'b1;
        state_d         = S_IDLE;
      end
      S_POP: begin
        if (depth_q == '0) begin
          done_d    = 1'b1;
          res_d     = '{check_done: 1'b1,
                        connected: ((visited_q & vmask) == vmask),
                        edge_rejected: 1'b0};
          row_vld_d = '0;
          state_d   = S_IDLE;
        end else begin
          depth_d = depth_m1;
          state_d = S_STK;
        end
      end
      S_STK: begin
        xrd_d   = stk_rdata;
        state_d = S_ROW;
      end
      S_ROW: begin
        visited_d = visited_q | nb;
        pend_d    = nb;
        state_d   = S_PUSH;
      end
      S_PUSH: begin
        if (pend_q == '0) begin
          state_d = S_POP;
        end else begin
          stk_we  = 1'b1;
          depth_d = depth_q + DW'(1);
          pend_d  = pend_q & ~lsb_oh;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_vld_q <= '0;
      visited_q <= '0;
      pend_q    <= '0;
      depth_q   <= '0;
      xrd_q     <= '0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      row_vld_q <= row_vld_d;
      visited_q <= visited_d;
      pend_q    <= pend_d;
      depth_q   <= depth_d;
      xrd_q     <= xrd_d;
      done_q    <= done_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= ra_d;
    rb_q <= rb_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* bench/graph_connectivity_check_unit_tb.sv */
// Testbench for graph_connectivity_check_unit: edge loads and connectivity checks
// against a behavioural predictor of the adjacency matrix and depth-first walk.
// Depends on gcc_pkg and the RTL of the unit; self-contained otherwise.
`timescale 1ns / 100ps

module graph_connectivity_check_unit_tb;
  import gcc_pkg::*;

  localparam logic        CmdEdge     = 1'b0;
  localparam logic        CmdCheck    = 1'b1;
  localparam int unsigned Verts       = 64;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned WordsWanted = 400;
  localparam logic [ApbAddrW-1:0] CountAddr = ApbAddrW'(RegVertexCount) << 2;

  // one directed step: a register write or a word, with a typed reply where obvious
  typedef struct packed {
    logic        is_cfg;
    logic [6:0]  cfg_val;
    logic        cmd;
    logic [6:0]  va;
    logic [6:0]  vb;
    logic        typed;
    res_t        want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                cmd_i = 1'b0;
  logic [CountW-1:0]   vertex_a_i = '0;
  logic [CountW-1:0]   vertex_b_i = '0;
  logic                done_o, check_done_o, connected_o, edge_rejected_o;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // predictor state
  logic [Verts-1:0] graph_rows [Verts];
  logic [Verts-1:0] reached_mask;
  logic [5:0]       walk_stack [Verts];
  int unsigned      walk_depth;
  logic [6:0]       vcount_reg;

  res_t        replies_due [$];
  int unsigned faults = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  bit          burst = 1'b0;

  always #5 clk_i = ~clk_i;

  graph_connectivity_check_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .vertex_a_i      (vertex_a_i),
    .vertex_b_i      (vertex_b_i),
    .done_o          (done_o),
    .check_done_o    (check_done_o),
    .connected_o     (connected_o),
    .edge_rejected_o (edge_rejected_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  function automatic int unsigned active_vertices();
    if (vcount_reg == 7'd0) return 1;
    if (vcount_reg > 7'(Verts)) return Verts;
    return 32'(vcount_reg);
  endfunction

  function automatic logic [Verts-1:0] live_mask();
    int unsigned n;
    n = active_vertices();
    if (n >= Verts) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // depth-first walk from vertex one; neighbours are marked when pushed
  function automatic logic walk_reaches_all();
    logic [Verts-1:0] live, nbrs;
    logic [5:0]       here;
    int unsigned      n;
    n = active_vertices();
    live = live_mask();
    reached_mask = 64'd1;
    walk_stack[0] = 6'd0;
    walk_depth = 1;
    while (walk_depth > 0) begin
      walk_depth--;
      here = walk_stack[walk_depth];
      nbrs = graph_rows[here] & live & ~reached_mask;
      for (int unsigned j = 0; j < n; j++) begin
        if (nbrs[j] && walk_depth < Verts) begin
          reached_mask[j] = 1'b1;
          walk_stack[walk_depth] = 6'(j);
          walk_depth++;
        end
      end
    end
    for (int i = 0; i < Verts; i++) graph_rows[i] = '0;
    return (reached_mask & live) == live;
  endfunction

  function automatic res_t predict_reply(logic c, logic [6:0] a, logic [6:0] b);
    res_t        r;
    int unsigned n;
    logic [5:0]  ia, ib;
    r = '0;
    if (c == CmdCheck) begin
      r.check_done = 1'b1;
      r.connected  = walk_reaches_all();
    end else begin
      n = active_vertices();
      r.edge_rejected = (a == 0) || (b == 0) || (a > n) || (b > n);
      if (!r.edge_rejected) begin
        ia = 6'(a - 7'd1);
        ib = 6'(b - 7'd1);
        graph_rows[ia][ib] = 1'b1;
        graph_rows[ib][ia] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic put_word(input logic c, input logic [6:0] a, input logic [6:0] b,
                          input logic typed, input res_t want);
    res_t guess;
    int   gap;
    start      <= 1'b1;
    cmd_i      <= c;
    vertex_a_i <= a;
    vertex_b_i <= b;
    do @(posedge clk_i); while (busy);
    guess = predict_reply(c, a, b);
    replies_due.insert(replies_due.size(), typed ? want : guess);
    words_sent++;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // valid edge, now and then preceded by a junk word
  task automatic put_edge(input int unsigned u, input int unsigned v);
    if ($urandom_range(0, 7) == 0)
      put_word(CmdEdge, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 1'b0, '0);
    put_word(CmdEdge, 7'(u), 7'(v), 1'b0, '0);
  endtask

  // hold off until every reply is in and the unit has settled
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input logic [6:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CountAddr;
    pwdata  <= ApbDataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    vcount_reg = v;
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== ApbDataW'(v)) begin
      $display("%0t: vertex_count readback expected %0d, got %0d", $time, v, prdata);
      faults++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected word, got done/conn/rej %b/%b/%b", $time,
                 check_done_o, connected_o, edge_rejected_o);
        faults++;
      end else if ({check_done_o, connected_o, edge_rejected_o} !== replies_due[0]) begin
        $display("%0t: mismatch, expected done/conn/rej %b/%b/%b, got %b/%b/%b", $time,
                 replies_due[0].check_done, replies_due[0].connected,
                 replies_due[0].edge_rejected, check_done_o, connected_o, edge_rejected_o);
        faults++;
        void'(replies_due.pop_front());
      end else begin
        void'(replies_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  plan_row_t plan [28] = '{
    // after reset the count is one: a lone vertex is connected
    '{1'b0, 7'd0,   CmdCheck, 7'd0,   7'd0,   1'b1, res_t'(3'b110)},
    '{1'b0, 7'd0,   CmdEdge,  7'd0,   7'd1,   1'b1, res_t'(3'b001)},
    '{1'b0, 7'd0,   CmdEdge,  7'd1,   7'd2,   1'b1, res_t'(3'b001)},
    '{1'b0, 7'd0,   CmdEdge,  7'd1,   7'd1,   1'b1, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdCheck, 7'd0,   7'd0,   1'b1, res_t'(3'b110)},
    '{1'b1, 7'd64,  CmdEdge,  7'd0,   7'd0,   1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd64,  7'd1,   1'b1, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd127, 7'd1,   1'b1, res_t'(3'b001)},
    '{1'b0, 7'd0,   CmdEdge,  7'd1,   7'd0,   1'b1, res_t'(3'b001)},
    '{1'b0, 7'd0,   CmdEdge,  7'd65,  7'd65,  1'b1, res_t'(3'b001)},
    '{1'b0, 7'd0,   CmdCheck, 7'd0,   7'd0,   1'b0, res_t'(3'b000)},
    // zero count behaves as one
    '{1'b1, 7'd0,   CmdEdge,  7'd0,   7'd0,   1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd1,   7'd1,   1'b1, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd1,   7'd2,   1'b1, res_t'(3'b001)},
    '{1'b0, 7'd0,   CmdCheck, 7'd0,   7'd0,   1'b1, res_t'(3'b110)},
    // count above capacity is clamped; duplicate edge
    '{1'b1, 7'd127, CmdEdge,  7'd0,   7'd0,   1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd64,  7'd64,  1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd63,  7'd64,  1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd64,  7'd63,  1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd1,   7'd64,  1'b0, res_t'(3'b000)},
    // shrink with stale edges still loaded
    '{1'b1, 7'd3,   CmdEdge,  7'd0,   7'd0,   1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd1,   7'd2,   1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd3,   7'd2,   1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdCheck, 7'd127, 7'd127, 1'b0, res_t'(3'b000)},
    // matrix must be empty after a check
    '{1'b1, 7'd2,   CmdEdge,  7'd0,   7'd0,   1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdCheck, 7'd0,   7'd0,   1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdEdge,  7'd2,   7'd1,   1'b0, res_t'(3'b000)},
    '{1'b0, 7'd0,   CmdCheck, 7'd0,   7'd85,  1'b0, res_t'(3'b000)}
  };

  initial begin : stimulus
    int unsigned n, k, u, v;
    logic [6:0]  cnt;
    for (int i = 0; i < Verts; i++) begin
      graph_rows[i] = '0;
      walk_stack[i] = '0;
    end
    reached_mask = '0;
    walk_depth   = 0;
    vcount_reg   = 7'd1;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        set_vertex_count(plan[i].cfg_val);
      else
        put_word(plan[i].cmd, plan[i].va, plan[i].vb, plan[i].typed, plan[i].want);
    end

    while (words_sent < WordsWanted) begin
      case ($urandom_range(0, 15))
        0:       cnt = 7'd0;
        1:       cnt = 7'd127;
        2:       cnt = 7'd64;
        3:       cnt = 7'($urandom_range(0, 127));
        default: cnt = 7'($urandom_range(2, 12));
      endcase
      set_vertex_count(cnt);
      n = active_vertices();
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) begin
        // spanning tree, so the check should come back connected
        for (v = 2; v <= n; v++) begin
          u = $urandom_range(1, v - 1);
          if ($urandom_range(0, 1) == 1) put_edge(u, v);
          else put_edge(v, u);
        end
        k = $urandom_range(0, 3);
      end else begin
        k = $urandom_range(0, (n < 18) ? n + 2 : 20);
      end
      repeat (k) put_edge($urandom_range(1, n), $urandom_range(1, n));
      if ($urandom_range(0, 5) == 0) set_vertex_count(7'($urandom_range(1, n)));
      if ($urandom_range(0, 9) == 0) drain();
      put_word(CmdCheck, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 1'b0, '0);
    end

    drain();
    repeat (350) @(posedge clk_i);
    if (faults == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* graph_connectivity_check_unit.f */
rtl/core/gcc_pkg.sv
rtl/core/gcc_ram.sv
rtl/core/gcc_ctrl.sv
rtl/core/graph_connectivity_check_unit.sv
bench/graph_connectivity_check_unit_tb.sv
